@@ hw/rtl/tts_pkg.sv @@
// Shared types and constants for the English text trigram scorer.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int BAND_W          = 17;
  localparam int OUT_W           = 16;
  localparam int SCALE           = 100000;

  localparam logic [BAND_W-1:0] TRI_LOW_RST  = 17'd2722;
  localparam logic [BAND_W-1:0] TRI_HIGH_RST = 17'd12722;
  localparam logic [BAND_W-1:0] E_LOW_RST    = 17'd7576;
  localparam logic [BAND_W-1:0] E_HIGH_RST   = 17'd17576;

  typedef enum logic [1:0] {
    REG_TRI_LOW  = 2'd0,
    REG_TRI_HIGH = 2'd1,
    REG_E_LOW    = 2'd2,
    REG_E_HIGH   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic             is_english;
    logic [OUT_W-1:0] trigram_hits;
    logic [OUT_W-1:0] e_total;
    logic [OUT_W-1:0] text_length;
  } out_t;

  typedef struct packed {
    logic [BAND_W-1:0] tri_low;
    logic [BAND_W-1:0] tri_high;
    logic [BAND_W-1:0] e_low;
    logic [BAND_W-1:0] e_high;
  } bands_t;

endpackage

`default_nettype wire

@@ hw/rtl/english_text_trigram_scorer_top.sv @@
// The verdict for a text passes through stage A, stage B and the result register in turn.
// Throughput: one byte per cycle while in_ready is high; the saturating counters and the
// trigram window close per byte. The band products are formed in one registered stage and
// compared in the next. Reset (rst_n, synchronous, active low) clears the counters, window and
// pipeline valid flags, and loads the band registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module english_text_trigram_scorer_top #(
  parameter int COUNT_WIDTH = tts_pkg::COUNT_WIDTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  tts_pkg::in_t       in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output tts_pkg::out_t      out_data,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [3:0]          paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tts_pkg::bands_t        bands_r;
  tts_pkg::reg_idx_t      reg_idx;
  logic                   in_fire;
  logic                   text_done;
  logic                   take_ready;
  logic [COUNT_WIDTH-1:0] len_nxt, hits_nxt, es_nxt;
  logic [tts_pkg::BAND_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign reg_idx = tts_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bands_r.tri_low  <= tts_pkg::TRI_LOW_RST;
      bands_r.tri_high <= tts_pkg::TRI_HIGH_RST;
      bands_r.e_low    <= tts_pkg::E_LOW_RST;
      bands_r.e_high   <= tts_pkg::E_HIGH_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        tts_pkg::REG_TRI_LOW:  bands_r.tri_low  <= pwdata[tts_pkg::BAND_W-1:0];
        tts_pkg::REG_TRI_HIGH: bands_r.tri_high <= pwdata[tts_pkg::BAND_W-1:0];
        tts_pkg::REG_E_LOW:    bands_r.e_low    <= pwdata[tts_pkg::BAND_W-1:0];
        tts_pkg::REG_E_HIGH:   bands_r.e_high   <= pwdata[tts_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tts_pkg::REG_TRI_LOW:  rd_val = bands_r.tri_low;
      tts_pkg::REG_TRI_HIGH: rd_val = bands_r.tri_high;
      tts_pkg::REG_E_LOW:    rd_val = bands_r.e_low;
      tts_pkg::REG_E_HIGH:   rd_val = bands_r.e_high;
      default:               rd_val = '0;
    endcase
  end
  assign prdata = 32'(rd_val);

  // Any byte may stall while a finished text still waits in the first verdict stage.
  assign in_ready = take_ready;
  assign in_fire  = in_valid && in_ready;

  tts_count #(.COUNT_WIDTH(COUNT_WIDTH)) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .text_done (text_done),
    .len_nxt   (len_nxt),
    .hits_nxt  (hits_nxt),
    .es_nxt    (es_nxt)
  );

  tts_verdict #(.COUNT_WIDTH(COUNT_WIDTH)) u_verdict (
    .clk        (clk),
    .rst_n      (rst_n),
    .bands      (bands_r),
    .text_done  (text_done),
    .len_in     (len_nxt),
    .hits_in    (hits_nxt),
    .es_in      (es_nxt),
    .take_ready (take_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/tts_count.sv @@
// Per-byte trigram window and saturating counters for one text.
`timescale 1ns / 1ps
`default_nettype none

module tts_count #(
  parameter int COUNT_WIDTH = tts_pkg::COUNT_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_fire,
  input  tts_pkg::in_t          in_data,
  output logic                  text_done,
  output logic [COUNT_WIDTH-1:0] len_nxt,
  output logic [COUNT_WIDTH-1:0] hits_nxt,
  output logic [COUNT_WIDTH-1:0] es_nxt
);

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [7:0]             older_r;
  logic [7:0]             newer_r;
  logic [COUNT_WIDTH-1:0] bytes_r;
  logic [COUNT_WIDTH-1:0] hits_r;
  logic [COUNT_WIDTH-1:0] es_r;
  logic                   hit;

  function automatic logic is_target(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    return (a == CH_T && b == CH_H && c == CH_E) ||
           (a == CH_A && b == CH_N && c == CH_D) ||
           (a == CH_I && b == CH_N && c == CH_G) ||
           (a == CH_H && b == CH_E && c == CH_R) ||
           (a == CH_H && b == CH_A && c == CH_T);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // A trigram needs two earlier bytes of the same text in the window.
  assign hit       = (bytes_r >= COUNT_WIDTH'(2)) &&
                     is_target(older_r, newer_r, in_data.char_code);
  assign len_nxt   = sat_inc(bytes_r);
  assign hits_nxt  = hit ? sat_inc(hits_r) : hits_r;
  assign es_nxt    = (in_data.char_code == CH_E) ? sat_inc(es_r) : es_r;
  assign text_done = in_fire && in_data.last_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      bytes_r <= '0;
      hits_r  <= '0;
      es_r    <= '0;
    end else if (in_fire) begin
      if (in_data.last_char) begin
        older_r <= '0;
        newer_r <= '0;
        bytes_r <= '0;
        hits_r  <= '0;
        es_r    <= '0;
      end else begin
        older_r <= newer_r;
        newer_r <= in_data.char_code;
        bytes_r <= len_nxt;
        hits_r  <= hits_nxt;
        es_r    <= es_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_hits_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= bytes_r)
    else $error("trigram count exceeds byte count");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    text_done |=> (bytes_r == '0) && (hits_r == '0) && (es_r == '0))
    else $error("counters not cleared after the last byte");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tts_verdict.sv @@
// Verdict pipeline: finished counts, band products, band compares, result register.
`timescale 1ns / 1ps
`default_nettype none

module tts_verdict #(
  parameter int COUNT_WIDTH = tts_pkg::COUNT_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tts_pkg::bands_t        bands,
  input  wire                    text_done,
  input  wire [COUNT_WIDTH-1:0]  len_in,
  input  wire [COUNT_WIDTH-1:0]  hits_in,
  input  wire [COUNT_WIDTH-1:0]  es_in,
  output logic                   take_ready,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tts_pkg::out_t          out_data
);

  localparam int P_W   = COUNT_WIDTH + tts_pkg::BAND_W;
  localparam int EXT_W = (COUNT_WIDTH > tts_pkg::OUT_W) ? COUNT_WIDTH : tts_pkg::OUT_W;
  localparam logic [EXT_W-1:0] OUT_MAX_EXT = EXT_W'((1 << tts_pkg::OUT_W) - 1);
  localparam logic [P_W-1:0]   SCALE_P     = P_W'(tts_pkg::SCALE);

  // Stage A: counts of a finished text.
  logic                   va_r;
  logic [COUNT_WIDTH-1:0] len_a_r;
  logic [COUNT_WIDTH-1:0] hits_a_r;
  logic [COUNT_WIDTH-1:0] es_a_r;
  // Stage B: products and clamped counts.
  logic                   vb_r;
  logic                   short_b_r;
  logic [P_W-1:0]         tl_b_r, th_b_r, el_b_r, eh_b_r, hs_b_r, es_b_r;
  logic [tts_pkg::OUT_W-1:0] hits_b_r, e_b_r, len_b_r;
  // Stage C: result register.
  logic                   out_valid_r;
  tts_pkg::out_t          out_data_r;

  logic                   ready_a, ready_b, ready_c;
  logic [COUNT_WIDTH-1:0] subs_a;
  logic                   eng_nxt;

  function automatic logic [tts_pkg::OUT_W-1:0] clamp(input logic [COUNT_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return (ext > OUT_MAX_EXT) ? OUT_MAX_EXT[tts_pkg::OUT_W-1:0] : ext[tts_pkg::OUT_W-1:0];
  endfunction

  assign ready_c    = !out_valid_r || out_ready;
  assign ready_b    = !vb_r || ready_c;
  assign ready_a    = !va_r || ready_b;
  assign take_ready = ready_a;
  assign subs_a     = len_a_r - COUNT_WIDTH'(2);

  assign eng_nxt = !short_b_r &&
                   (tl_b_r <= hs_b_r) && (hs_b_r <= th_b_r) &&
                   (el_b_r <= es_b_r) && (es_b_r <= eh_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= text_done;
      if (ready_b) vb_r <= va_r;
      if (ready_c) out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && text_done) begin
      len_a_r  <= len_in;
      hits_a_r <= hits_in;
      es_a_r   <= es_in;
    end
    if (ready_b && va_r) begin
      short_b_r <= len_a_r < COUNT_WIDTH'(3);
      tl_b_r    <= P_W'(bands.tri_low)  * P_W'(subs_a);
      th_b_r    <= P_W'(bands.tri_high) * P_W'(subs_a);
      el_b_r    <= P_W'(bands.e_low)    * P_W'(len_a_r);
      eh_b_r    <= P_W'(bands.e_high)   * P_W'(len_a_r);
      hs_b_r    <= P_W'(hits_a_r) * SCALE_P;
      es_b_r    <= P_W'(es_a_r)   * SCALE_P;
      hits_b_r  <= clamp(hits_a_r);
      e_b_r     <= clamp(es_a_r);
      len_b_r   <= clamp(len_a_r);
    end
    if (ready_c && vb_r) begin
      out_data_r.is_english   <= eng_nxt;
      out_data_r.trigram_hits <= hits_b_r;
      out_data_r.e_total      <= e_b_r;
      out_data_r.text_length  <= len_b_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_short_not_english: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_english |-> out_data_r.text_length >= 16'd3)
    else $error("text shorter than three bytes judged English");
  a_counts_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.trigram_hits <= out_data_r.text_length) &&
                    (out_data_r.e_total <= out_data_r.text_length))
    else $error("reported count exceeds text length");
`endif

endmodule

`default_nettype wire
